[rtl/buss_pkg.sv]
// Package for the bounded unique set store.
// Holds the sequencer state type, action codes and default sizes.
// No dependencies.
package buss_pkg;

	localparam int DEPTH_DEF      = 32;
	localparam int ELEM_WIDTH_DEF = 16;
	localparam int ELEM_IN_W      = 16;
	localparam int ACTION_W       = 2;

	typedef enum logic [ACTION_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_QUERY  = 2'd2,
		ACT_SPARE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SHIFT,
		ST_DONE
	} seq_state_t;

endpackage

[rtl/bounded_unique_set_store_unit.sv]
// Bounded set of distinct values in a packed single-port-read memory.
// One address counter and one comparator step through the store under
// a small sequencer. Depends on buss_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall, action, element) carries one request
//   per beat: insert, delete or membership query. Action code 3 is a query.
//   Output channel (out_valid/out_stall) carries one result beat per request.
//   in_stall is high while a request is being worked on; one request at a
//   time. The result sits in an output register, so the next request is
//   taken while that result still waits for the receiver.
//   A search reads the live entries in order and stops at a hit, or runs
//   over all live entries on a miss. A delete that hits also shifts the
//   later entries down by one place. One memory read port, one entry
//   compared per cycle.
//   Reset clears the live count, so the set is empty; store contents are
//   left as they are and never read before being written.
//   If the receiver stalls, the result holds; a finished request waits in
//   the sequencer until the output register frees up.
module bounded_unique_set_store_unit #(
	parameter int DEPTH      = buss_pkg::DEPTH_DEF,
	parameter int ELEM_WIDTH = buss_pkg::ELEM_WIDTH_DEF,
	parameter int CW         = $clog2(DEPTH + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [buss_pkg::ACTION_W-1:0]  action,
	input  logic [buss_pkg::ELEM_IN_W-1:0] element,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           was_member,
	output logic                           dropped,
	output logic [CW-1:0]                  count_after,
	output logic                           is_empty,
	output logic                           is_full
);
	import buss_pkg::*;

	localparam int AW = $clog2(DEPTH);

	seq_state_t state_q, state_d;

	logic [ELEM_WIDTH-1:0] mem [DEPTH];
	logic [ELEM_WIDTH-1:0] rd_data_q;

	logic [ELEM_WIDTH+ELEM_IN_W-1:0] elem_ext;
	logic [ELEM_WIDTH-1:0]           elem_in;

	logic [ACTION_W-1:0]   act_q;
	logic [ELEM_WIDTH-1:0] elem_q;
	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         scan_q;
	logic                  pend_q;
	logic [AW-1:0]         pend_idx_q;
	logic                  member_q;
	logic                  drop_q;

	logic                  out_valid_q;
	logic                  was_member_q;
	logic                  dropped_q;
	logic [CW-1:0]         count_after_q;
	logic                  is_empty_q;
	logic                  is_full_q;

	logic                  in_beat;
	logic                  hit;
	logic                  issue;
	logic [AW-1:0]         rd_addr;
	logic                  miss_done;
	logic                  shift_done;
	logic                  ins_we;
	logic                  shift_we;
	logic                  we;
	logic [AW-1:0]         wr_addr;
	logic [ELEM_WIDTH-1:0] wr_data;
	logic                  out_free;
	logic                  is_del;
	logic                  is_ins;
	logic                  cnt_full;

	// element is used masked (or zero-extended) to the stored width
	assign elem_ext = {{ELEM_WIDTH{1'b0}}, element};
	assign elem_in  = elem_ext[ELEM_WIDTH-1:0];

	assign in_beat  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign is_del   = (act_q == ACT_DELETE);
	assign is_ins   = (act_q == ACT_INSERT);
	assign cnt_full = (cnt_q == CW'(DEPTH));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SEARCH;
			end
			ST_SEARCH: begin
				if (hit) state_d = is_del ? ST_SHIFT : ST_DONE;
				else if (miss_done) state_d = ST_DONE;
			end
			ST_SHIFT: begin
				if (shift_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall   = 1'b1;
		hit        = 1'b0;
		issue      = 1'b0;
		miss_done  = 1'b0;
		shift_done = 1'b0;
		ins_we     = 1'b0;
		shift_we   = 1'b0;
		rd_addr    = scan_q[AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_SEARCH: begin
				hit       = pend_q && (rd_data_q == elem_q);
				issue     = !hit && (scan_q < cnt_q);
				miss_done = !pend_q && (scan_q == cnt_q);
				ins_we    = miss_done && is_ins && !cnt_full;
			end
			ST_SHIFT: begin
				issue      = (scan_q < cnt_q);
				shift_done = !pend_q && (scan_q == cnt_q);
				shift_we   = pend_q;
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// insert appends at the count; shift moves entry i+1 down to i
	always_comb begin
		we      = ins_we || shift_we;
		wr_addr = shift_we ? AW'(pend_idx_q - AW'(1)) : cnt_q[AW-1:0];
		wr_data = shift_we ? rd_data_q : elem_q;
	end

	always_ff @(posedge clk) begin
		if (we) mem[wr_addr] <= wr_data;
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			pend_q  <= 1'b0;
			scan_q  <= '0;
		end else begin
			state_q <= state_d;
			if (in_beat) begin
				scan_q <= '0;
				pend_q <= 1'b0;
			end else begin
				pend_q <= issue;
				if (hit) scan_q <= CW'(pend_idx_q) + CW'(1);
				else if (issue) scan_q <= scan_q + CW'(1);
			end
			if (ins_we) cnt_q <= cnt_q + CW'(1);
			else if (shift_done) cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			act_q    <= action;
			elem_q   <= elem_in;
			member_q <= 1'b0;
			drop_q   <= 1'b0;
		end else begin
			if (hit) member_q <= 1'b1;
			if (miss_done && is_ins && cnt_full) drop_q <= 1'b1;
		end
		if (issue) pend_idx_q <= rd_addr;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			was_member_q  <= member_q;
			dropped_q     <= drop_q;
			count_after_q <= cnt_q;
			is_empty_q    <= (cnt_q == '0);
			is_full_q     <= cnt_full;
		end
	end

	assign out_valid   = out_valid_q;
	assign was_member  = was_member_q;
	assign dropped     = dropped_q;
	assign count_after = count_after_q;
	assign is_empty    = is_empty_q;
	assign is_full     = is_full_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("live count above depth");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		##1 (cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + CW'(1) ||
		cnt_q == $past(cnt_q) - CW'(1)))
		else $error("live count moved by more than one");

	a_shift_addr: assert property (@(posedge clk) disable iff (!arst_n)
		shift_we |-> (CW'(pend_idx_q) < cnt_q && pend_idx_q != '0))
		else $error("shift touches an entry outside the live range");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && dropped) |-> (is_full && !was_member))
		else $error("dropped insert without a full set");

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("input taken while a request is in progress");

endmodule
